// ===== hdl/deadline_timer_table_top_defines.svh =====
// Assertion macros shared by the timer table modules.
// No dependencies; included inside module bodies.
`ifndef DEADLINE_TIMER_TABLE_TOP_DEFINES_SVH
`define DEADLINE_TIMER_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define DTT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle during reset.
`define DTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dtt_pkg.sv =====
// Types and constants for the deadline timer table.
// No dependencies.
package dtt_pkg;

    localparam int NOW_W      = 52;
    localparam int DELAY_W    = 32;
    localparam int HANDLER_W  = 8;
    localparam int CTX_W      = 32;
    localparam int DEADLINE_W = 53;
    localparam int PROD_W     = 41;  // 31-bit delay times 10-bit scale

    localparam logic [DEADLINE_W-1:0] DEADLINE_NONE = '1;
    localparam logic [9:0]            MS_TO_US      = 10'd1000;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_RUN      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED_SCAN,
        ST_SCHED_DONE,
        ST_RUN_MIN,
        ST_RUN_FIRE,
        ST_RUN_DONE
    } t_state;

    typedef struct packed {
        logic load;        // capture the accepted item
        logic acc_clear;   // reset earliest deadline before a run
        logic scan_start;  // point the scan at slot 0
        logic scan_step;   // advance the scan
        logic kill_scan;   // match and kill on the current slot
        logic min_scan;    // fold current slot into the earliest deadline
        logic expire;      // drop the current slot if expired
        logic emit_sched;  // insert and post the schedule result
        logic emit_fired;  // post a fired result for the current slot
        logic emit_close;  // post the closing result of a run
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_last;
        logic fire_live;
        logic out_free;
    } t_ctl_status;

endpackage

// ===== hdl/dtt_if.sv =====
// Item channels of the deadline timer table: input and result streams.
// Depends on dtt_pkg.
interface dtt_in_if;
    import dtt_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [NOW_W-1:0]            now_us;
    logic signed [DELAY_W-1:0]   delay_ms;
    logic [HANDLER_W-1:0]        handler_id;
    logic [CTX_W-1:0]            context_tag;

    modport source (output valid, command, now_us, delay_ms, handler_id, context_tag,
                    input ready);
    modport sink (input valid, command, now_us, delay_ms, handler_id, context_tag,
                  output ready);
endinterface

interface dtt_out_if;
    import dtt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   fired;
    logic [HANDLER_W-1:0]   fired_handler;
    logic [CTX_W-1:0]       fired_context;
    logic [DEADLINE_W-1:0]  earliest_deadline;
    logic                   table_full;
    logic                   last_result;

    modport source (output valid, fired, fired_handler, fired_context, earliest_deadline,
                    table_full, last_result, input ready);
    modport sink (input valid, fired, fired_handler, fired_context, earliest_deadline,
                  table_full, last_result, output ready);
endinterface

// ===== hdl/dtt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/dtt_datapath.sv =====
// Timer table datapath: slot store, scan counter, earliest deadline, result register.
// Depends on dtt_pkg, dtt_ram and the assertion macro header.
module dtt_datapath #(
    parameter int TABLE_DEPTH  = 16,
    parameter int CONTEXT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dtt_pkg::t_ctl_cmd               i_cmd,
    output dtt_pkg::t_ctl_status            o_status,
    input  logic [dtt_pkg::NOW_W-1:0]       i_now_us,
    input  logic signed [dtt_pkg::DELAY_W-1:0] i_delay_ms,
    input  logic [dtt_pkg::HANDLER_W-1:0]   i_handler_id,
    input  logic [dtt_pkg::CTX_W-1:0]       i_context_tag,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_fired,
    output logic [dtt_pkg::HANDLER_W-1:0]   o_fired_handler,
    output logic [dtt_pkg::CTX_W-1:0]       o_fired_context,
    output logic [dtt_pkg::DEADLINE_W-1:0]  o_earliest_deadline,
    output logic                            o_table_full,
    output logic                            o_last_result
);
    import dtt_pkg::*;
    `include "deadline_timer_table_top_defines.svh"

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CB = CONTEXT_BITS;
    localparam int RW = HANDLER_W + CB + DEADLINE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    // item registers
    logic [NOW_W-1:0]      r_now;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_neg;
    logic [HANDLER_W-1:0]  r_handler;
    logic [CB-1:0]         r_ctx;

    // scan and table control
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_free_found;
    logic [IW-1:0]         r_free_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] r_killed;
    logic [DEADLINE_W-1:0] r_earliest;

    // result register
    logic                  r_out_valid;
    logic                  r_out_fired;
    logic [HANDLER_W-1:0]  r_out_handler;
    logic [CTX_W-1:0]      r_out_context;
    logic [DEADLINE_W-1:0] r_out_earliest;
    logic                  r_out_full;
    logic                  r_out_last;

    logic [RW-1:0]         rd_data;
    logic [DEADLINE_W-1:0] rd_deadline;
    logic [CB-1:0]         rd_ctx;
    logic [HANDLER_W-1:0]  rd_handler;
    logic [CB+CTX_W-1:0]   ctx_in_ext;
    logic [CB+CTX_W-1:0]   rd_ctx_ext;
    logic [DEADLINE_W-1:0] due;
    logic                  ins_ok;
    logic [DEADLINE_W-1:0] sched_earliest;
    logic                  cur_valid;
    logic                  cur_killed;
    logic                  pending;
    logic                  slot_expired;
    logic                  slot_match;
    logic                  out_free;
    logic                  any_emit;

    assign ctx_in_ext  = {{CB{1'b0}}, i_context_tag};
    assign rd_deadline = rd_data[DEADLINE_W-1:0];
    assign rd_ctx      = rd_data[DEADLINE_W +: CB];
    assign rd_handler  = rd_data[RW-1 -: HANDLER_W];
    assign rd_ctx_ext  = {{CTX_W{1'b0}}, rd_ctx};

    assign cur_valid    = r_valid[r_idx];
    assign cur_killed   = r_killed[r_idx];
    assign pending      = rd_deadline > DEADLINE_W'(r_now);
    assign slot_expired = cur_valid && !pending;
    assign slot_match   = cur_valid && !cur_killed && (rd_handler == r_handler)
                          && (rd_ctx == r_ctx);

    assign due            = DEADLINE_W'(r_now) + DEADLINE_W'(r_prod);
    assign ins_ok         = !r_neg && r_free_found;
    assign sched_earliest = (ins_ok && (due < r_earliest)) ? due : r_earliest;

    assign out_free = !r_out_valid || i_out_ready;
    assign any_emit = i_cmd.emit_sched || i_cmd.emit_fired || i_cmd.emit_close;

    // read address follows the next scan index so data lines up with r_idx
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.scan_start) begin
            n_idx = '0;
        end else if (i_cmd.scan_step) begin
            n_idx = r_idx + IW'(1);
        end
    end

    dtt_ram #(
        .WIDTH(RW),
        .DEPTH(TABLE_DEPTH)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.emit_sched && ins_ok),
        .i_waddr(r_free_idx),
        .i_wdata({r_handler, r_ctx, due}),
        .i_raddr(n_idx),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_valid     <= '0;
            r_killed    <= '0;
            r_earliest  <= DEADLINE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.acc_clear) begin
                r_earliest <= DEADLINE_NONE;
            end
            if (i_cmd.kill_scan && slot_match) begin
                r_killed[r_idx] <= 1'b1;
            end
            if (i_cmd.min_scan && cur_valid && pending && (rd_deadline < r_earliest)) begin
                r_earliest <= rd_deadline;
            end
            if (i_cmd.expire && slot_expired) begin
                r_valid[r_idx]  <= 1'b0;
                r_killed[r_idx] <= 1'b0;
            end
            if (i_cmd.emit_sched) begin
                r_earliest <= sched_earliest;
                if (ins_ok) begin
                    r_valid[r_free_idx]  <= 1'b1;
                    r_killed[r_free_idx] <= 1'b0;
                end
            end
            if (any_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now        <= i_now_us;
            r_prod       <= PROD_W'(i_delay_ms[DELAY_W-2:0]) * PROD_W'(MS_TO_US);
            r_neg        <= i_delay_ms[DELAY_W-1];
            r_handler    <= i_handler_id;
            r_ctx        <= ctx_in_ext[CB-1:0];
            r_free_found <= 1'b0;
        end else if (i_cmd.kill_scan && !cur_valid && !r_free_found) begin
            r_free_found <= 1'b1;
            r_free_idx   <= r_idx;
        end
        if (i_cmd.emit_sched) begin
            r_out_fired    <= 1'b0;
            r_out_handler  <= '0;
            r_out_context  <= '0;
            r_out_earliest <= sched_earliest;
            r_out_full     <= !r_neg && !r_free_found;
            r_out_last     <= 1'b1;
        end else if (i_cmd.emit_fired) begin
            r_out_fired    <= 1'b1;
            r_out_handler  <= rd_handler;
            r_out_context  <= rd_ctx_ext[CTX_W-1:0];
            r_out_earliest <= r_earliest;
            r_out_full     <= 1'b0;
            r_out_last     <= 1'b0;
        end else if (i_cmd.emit_close) begin
            r_out_fired    <= 1'b0;
            r_out_handler  <= '0;
            r_out_context  <= '0;
            r_out_earliest <= r_earliest;
            r_out_full     <= 1'b0;
            r_out_last     <= 1'b1;
        end
    end

    assign o_status.scan_last = (r_idx == LAST_IDX);
    assign o_status.fire_live = slot_expired && !cur_killed;
    assign o_status.out_free  = out_free;

    assign o_out_valid         = r_out_valid;
    assign o_fired             = r_out_fired;
    assign o_fired_handler     = r_out_handler;
    assign o_fired_context     = r_out_context;
    assign o_earliest_deadline = r_out_earliest;
    assign o_table_full        = r_out_full;
    assign o_last_result       = r_out_last;

    `DTT_ASSERT_IMPL(a_emit_room, i_clk, i_rst_n, any_emit, out_free,
                     "result posted over one not yet taken")
    `DTT_ASSERT_IMPL(a_fire_live, i_clk, i_rst_n, i_cmd.emit_fired,
                     slot_expired && !cur_killed, "fired result for a slot not live and due")
    `DTT_ASSERT_IMPL(a_full_last, i_clk, i_rst_n, r_out_valid && r_out_full,
                     r_out_last && !r_out_fired, "table full flag outside a schedule result")
endmodule

// ===== hdl/dtt_ctrl.sv =====
// Timer table controller: sequences the slot scans and result posting.
// Depends on dtt_pkg and the assertion macro header.
module dtt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_command,
    output logic                 o_in_ready,
    input  dtt_pkg::t_ctl_status i_status,
    output dtt_pkg::t_ctl_cmd    o_cmd
);
    import dtt_pkg::*;
    `include "deadline_timer_table_top_defines.svh"

    t_state   r_state, n_state;
    t_ctl_cmd cmd;
    logic     fire_step;

    assign fire_step = !i_status.fire_live || i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    if (i_in_command == CMD_RUN) begin
                        cmd.acc_clear = 1'b1;
                        n_state       = ST_RUN_MIN;
                    end else begin
                        n_state = ST_SCHED_SCAN;
                    end
                end
            end
            ST_SCHED_SCAN: begin
                cmd.kill_scan = 1'b1;
                cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_SCHED_DONE;
                end
            end
            ST_SCHED_DONE: begin
                if (i_status.out_free) begin
                    cmd.emit_sched = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_RUN_MIN: begin
                cmd.min_scan = 1'b1;
                if (i_status.scan_last) begin
                    cmd.scan_start = 1'b1;
                    n_state        = ST_RUN_FIRE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_RUN_FIRE: begin
                if (fire_step) begin
                    cmd.scan_step  = 1'b1;
                    cmd.expire     = 1'b1;
                    cmd.emit_fired = i_status.fire_live;
                    if (i_status.scan_last) begin
                        n_state = ST_RUN_DONE;
                    end
                end
            end
            ST_RUN_DONE: begin
                if (i_status.out_free) begin
                    cmd.emit_close = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    `DTT_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, (r_state == ST_IDLE) && !i_in_valid,
                     r_state == ST_IDLE, "left idle without an item")
    `DTT_ASSERT_NEXT(a_min_to_fire, i_clk, i_rst_n,
                     (r_state == ST_RUN_MIN) && i_status.scan_last,
                     r_state == ST_RUN_FIRE, "minimum pass did not hand over to fire pass")
    `DTT_ASSERT_NEXT(a_fire_done, i_clk, i_rst_n,
                     (r_state == ST_RUN_FIRE) && i_status.scan_last && fire_step,
                     r_state == ST_RUN_DONE, "fire pass did not close after last slot")
endmodule

// ===== hdl/deadline_timer_table_top.sv =====
// Deadline timer table top level: wires controller, datapath and item channels.
// Depends on dtt_pkg, dtt_if, dtt_ctrl and dtt_datapath.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  i_in     | in  | valid / ready | command, now_us, delay_ms, handler_id, context_tag
//  o_out    | out | valid / ready | fired, fired_handler, fired_context,
//           |     |               | earliest_deadline, table_full, last_result
//
// Schedule: accept, scan one slot per cycle, post the result when the output is free.
// Run: one pass finds the earliest deadline, a second pass fires and drops due
// slots; both passes read the table through the slot RAM read port.
// Items are taken one at a time; a new item is accepted while the last result waits.
// A held result stalls the fire pass at the next live due slot.
// Reset clears slot valid/killed bits at once; no clearing pass.
module deadline_timer_table_top #(
    parameter int TABLE_DEPTH  = 16,
    parameter int CONTEXT_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtt_in_if.sink    i_in,
    dtt_out_if.source o_out
);
    import dtt_pkg::*;

    t_ctl_cmd    ctl_cmd;
    t_ctl_status ctl_status;

    dtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_command(i_in.command),
        .o_in_ready  (i_in.ready),
        .i_status    (ctl_status),
        .o_cmd       (ctl_cmd)
    );

    dtt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CONTEXT_BITS(CONTEXT_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (ctl_cmd),
        .o_status           (ctl_status),
        .i_now_us           (i_in.now_us),
        .i_delay_ms         (i_in.delay_ms),
        .i_handler_id       (i_in.handler_id),
        .i_context_tag      (i_in.context_tag),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_fired            (o_out.fired),
        .o_fired_handler    (o_out.fired_handler),
        .o_fired_context    (o_out.fired_context),
        .o_earliest_deadline(o_out.earliest_deadline),
        .o_table_full       (o_out.table_full),
        .o_last_result      (o_out.last_result)
    );
endmodule

// ===== tb/tb_deadline_timer_table_top.sv =====
// Self-checking testbench for deadline_timer_table_top: schedule, cancel and run
// commands checked against an in-bench timer table predictor.
// Depends on dtt_pkg, dtt_if and the deadline_timer_table_top RTL.
module tb_deadline_timer_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtt_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 360;
    localparam int TAIL_ITEMS   = 60;   // no idling once this few items remain
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam logic [NOW_W-1:0] NOW_MAX = '1;

    typedef struct packed {
        logic                  command;
        logic [NOW_W-1:0]      now_us;
        logic [DELAY_W-1:0]    delay_ms;
        logic [HANDLER_W-1:0]  handler;
        logic [CTX_W-1:0]      ctx_tag;
    } t_timer_cmd;

    typedef struct packed {
        logic                  fired;
        logic [HANDLER_W-1:0]  handler;
        logic [CTX_W-1:0]      ctx_tag;
        logic [DEADLINE_W-1:0] earliest;
        logic                  full;
        logic                  last;
    } t_timer_report;

    logic i_clk;
    logic i_rst_n;

    dtt_in_if  in_if ();
    dtt_out_if out_if ();

    deadline_timer_table_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted timer table
    logic                  tmr_valid   [SLOTS];
    logic                  tmr_killed  [SLOTS];
    logic [HANDLER_W-1:0]  tmr_handler [SLOTS];
    logic [CTX_W-1:0]      tmr_ctx     [SLOTS];
    logic [DEADLINE_W-1:0] tmr_due     [SLOTS];
    logic [DEADLINE_W-1:0] soonest_due;

    t_timer_cmd    pending_cmds[$];
    t_timer_report expected_reports[$];

    int cmds_total;
    int cmds_accepted;
    int reports_checked;
    int timers_fired;
    int inserts_dropped;
    int mismatches;
    int in_gap;
    int out_stall;
    bit in_bursty;
    bit out_bursty;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_timers();
        for (int i = 0; i < SLOTS; i++) begin
            tmr_valid[i]  = 1'b0;
            tmr_killed[i] = 1'b0;
        end
        soonest_due = DEADLINE_NONE;
    endtask

    task automatic predict_timers(t_timer_cmd c);
        t_timer_report rep;
        t_timer_report fires[$];
        logic [DEADLINE_W-1:0] due;
        int free_idx;
        rep = '0;
        if (c.command == CMD_SCHEDULE) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (tmr_valid[i] && !tmr_killed[i] && tmr_handler[i] == c.handler &&
                    tmr_ctx[i] == c.ctx_tag)
                    tmr_killed[i] = 1'b1;
            end
            // a negative delay only cancels
            if (!c.delay_ms[DELAY_W-1]) begin
                due = DEADLINE_W'(c.now_us) +
                      DEADLINE_W'(c.delay_ms) * DEADLINE_W'(MS_TO_US);
                free_idx = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!tmr_valid[i] && free_idx < 0) free_idx = i;
                if (free_idx < 0) begin
                    rep.full = 1'b1;
                    inserts_dropped++;
                end else begin
                    tmr_valid[free_idx]   = 1'b1;
                    tmr_killed[free_idx]  = 1'b0;
                    tmr_handler[free_idx] = c.handler;
                    tmr_ctx[free_idx]     = c.ctx_tag;
                    tmr_due[free_idx]     = due;
                    if (soonest_due > due) soonest_due = due;
                end
            end
        end else begin
            soonest_due = DEADLINE_NONE;
            for (int i = 0; i < SLOTS; i++) begin
                if (tmr_valid[i]) begin
                    if (tmr_due[i] > DEADLINE_W'(c.now_us)) begin
                        if (soonest_due > tmr_due[i]) soonest_due = tmr_due[i];
                    end else begin
                        // killed timers expire silently
                        if (!tmr_killed[i]) begin
                            rep = '0;
                            rep.fired   = 1'b1;
                            rep.handler = tmr_handler[i];
                            rep.ctx_tag = tmr_ctx[i];
                            fires.push_back(rep);
                        end
                        tmr_valid[i]  = 1'b0;
                        tmr_killed[i] = 1'b0;
                    end
                end
            end
            // every report of a run carries the recomputed earliest deadline
            foreach (fires[k]) begin
                fires[k].earliest = soonest_due;
                expected_reports.push_back(fires[k]);
                timers_fired++;
            end
            rep = '0;
        end
        rep.earliest = soonest_due;
        rep.last     = 1'b1;
        expected_reports.push_back(rep);
    endtask

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void add_cmd(logic cmd, logic [NOW_W-1:0] now,
                                    logic [DELAY_W-1:0] delay,
                                    logic [HANDLER_W-1:0] hnd, logic [CTX_W-1:0] ctx);
        t_timer_cmd c;
        c.command  = cmd;
        c.now_us   = now;
        c.delay_ms = delay;
        c.handler  = hnd;
        c.ctx_tag  = ctx;
        pending_cmds.push_back(c);
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            clear_timers();
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_timers('{in_if.command, in_if.now_us, in_if.delay_ms,
                                 in_if.handler_id, in_if.context_tag});
                cmds_accepted++;
            end
            if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 99) == 0)
                in_bursty = !in_bursty;
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    t_timer_cmd c;
                    c = pending_cmds.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.command     <= c.command;
                    in_if.now_us      <= c.now_us;
                    in_if.delay_ms    <= c.delay_ms;
                    in_if.handler_id  <= c.handler;
                    in_if.context_tag <= c.ctx_tag;
                    if (in_bursty && pending_cmds.size() > TAIL_ITEMS &&
                        $urandom_range(0, 3) == 0)
                        in_gap = $urandom_range(1, 7);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result with no expectation waiting");
                    mismatches++;
                end else begin
                    t_timer_report want;
                    want = expected_reports.pop_front();
                    compare_field("fired", 64'(want.fired), 64'(out_if.fired));
                    compare_field("fired_handler", 64'(want.handler),
                                  64'(out_if.fired_handler));
                    compare_field("fired_context", 64'(want.ctx_tag),
                                  64'(out_if.fired_context));
                    compare_field("earliest_deadline", 64'(want.earliest),
                                  64'(out_if.earliest_deadline));
                    compare_field("table_full", 64'(want.full), 64'(out_if.table_full));
                    compare_field("last_result", 64'(want.last), 64'(out_if.last_result));
                    reports_checked++;
                end
            end
            if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 99) == 0)
                out_bursty = !out_bursty;
            if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (out_bursty && pending_cmds.size() > TAIL_ITEMS &&
                    $urandom_range(0, 3) == 0)
                    out_stall = $urandom_range(1, 7);
            end
        end
    end

    // Stimulus
    initial begin
        logic [NOW_W-1:0]     cur_now;
        logic [HANDLER_W-1:0] hnd_pool [3];
        logic [CTX_W-1:0]     ctx_pool [3];
        logic [HANDLER_W-1:0] hnd;
        logic [CTX_W-1:0]     ctx;
        logic [31:0]          hi_bits;
        logic [31:0]          lo_bits;
        int                   random_count;
        int                   epoch_len;
        int                   r;

        in_if.valid       = 1'b0;
        in_if.command     = CMD_SCHEDULE;
        in_if.now_us      = '0;
        in_if.delay_ms    = '0;
        in_if.handler_id  = '0;
        in_if.context_tag = '0;
        out_if.ready      = 1'b0;
        i_rst_n           = 1'b0;
        in_gap            = 0;
        out_stall         = 0;
        in_bursty         = 1'b1;
        out_bursty        = 1'b1;

        // directed: field extremes, kill of a live timer, re-schedule of the same key,
        // silent expiry of a killed timer, deadline equal to now, full table
        add_cmd(CMD_SCHEDULE, '0, 32'd0, 8'h00, 32'h0000_0000);
        add_cmd(CMD_SCHEDULE, '0, 32'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        add_cmd(CMD_SCHEDULE, NOW_MAX, 32'd0, 8'h5A, 32'hA5A5_A5A5);
        add_cmd(CMD_SCHEDULE, '0, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000);
        add_cmd(CMD_SCHEDULE, '0, 32'h8000_0000, 8'h77, 32'h1234_5678);
        add_cmd(CMD_SCHEDULE, 52'd100, 32'd5, 8'h01, 32'h0000_0001);
        add_cmd(CMD_SCHEDULE, 52'd100, 32'd5, 8'h01, 32'h0000_0001);
        add_cmd(CMD_RUN, '0, 32'd0, 8'h00, 32'h0);
        add_cmd(CMD_RUN, 52'd5100, 32'd0, 8'h00, 32'h0);
        for (int k = 0; k < 14; k++)
            add_cmd(CMD_SCHEDULE, 52'd200, 32'd1, 8'(10 + k), 32'(10 + k));
        add_cmd(CMD_SCHEDULE, 52'd300, 32'd2, 8'd10, 32'd10);
        add_cmd(CMD_RUN, NOW_MAX, 32'd0, 8'h00, 32'h0);

        // random: epochs of related commands around a moving clock, each ending in a flush
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            epoch_len = $urandom_range(15, 45);
            if ($urandom_range(0, 3) == 0) begin
                cur_now = '0;
            end else begin
                hi_bits = $urandom_range(0, 32'hFFBFF);
                lo_bits = $urandom();
                cur_now = {hi_bits[19:0], lo_bits};
            end
            for (int k = 0; k < 3; k++) begin
                hnd_pool[k] = HANDLER_W'($urandom());
                ctx_pool[k] = $urandom();
            end
            for (int k = 0; k < epoch_len && random_count < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 6) == 0) begin
                    hnd = HANDLER_W'($urandom());
                    ctx = $urandom();
                end else begin
                    hnd = hnd_pool[$urandom_range(0, 2)];
                    ctx = ctx_pool[$urandom_range(0, 2)];
                end
                if (r < 48) begin
                    if ($urandom_range(0, 19) == 0)
                        add_cmd(CMD_SCHEDULE, cur_now, $urandom() & 32'h7FFF_FFFF, hnd, ctx);
                    else
                        add_cmd(CMD_SCHEDULE, cur_now, $urandom_range(0, 8), hnd, ctx);
                end else if (r < 62) begin
                    add_cmd(CMD_SCHEDULE, cur_now, $urandom() | 32'h8000_0000, hnd, ctx);
                end else if (r < 95) begin
                    add_cmd(CMD_RUN, cur_now, $urandom(), hnd, ctx);
                end else begin
                    // clock running backward
                    add_cmd(CMD_RUN, (cur_now > 52'd5000) ? cur_now - 52'd5000 : '0,
                            $urandom(), hnd, ctx);
                end
                cur_now += $urandom_range(0, 3000);
                random_count++;
            end
            add_cmd(CMD_RUN, NOW_MAX, 32'd0, 8'h00, 32'h0);
            random_count++;
        end
        cmds_total = pending_cmds.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // End of run
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        while (cmds_accepted != cmds_total || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d commands applied, %0d results checked against the timer table",
                 cmds_accepted, reports_checked);
        $display("%0d timers fired, %0d inserts dropped on a full table",
                 timers_fired, inserts_dropped);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("tb_deadline_timer_table_top: clean");
        end else begin
            $display("tb_deadline_timer_table_top: errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", expected_reports.size());
        $display("tb_deadline_timer_table_top: errors");
        $finish;
    end

endmodule
